/* sv/pfa_pkg.sv */
// Shared types and constants of the paged frame allocator.
// Holds request kinds, the controller-to-datapath command set and the status word.
// No dependencies.
package pfa_pkg;

    localparam int OFFSET_BITS_DEF   = 10;
    localparam int FRAME_COUNT_DEF   = 1024;
    localparam int MEMORY_BYTES_DEF  = 1048576;
    localparam int PROCESS_COUNT_DEF = 8;

    localparam int KIND_W = 2;
    localparam int PID_W  = 4;
    localparam int ADDR_W = 20;
    localparam int SIZE_W = 21;
    localparam int DATA_W = 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_READ  = 2'd2,
        KIND_WRITE = 2'd3
    } t_kind;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_LATCH,
        CMD_OWN_RD,
        CMD_CNT_CHK,
        CMD_ASN_INIT,
        CMD_ASN_CHK,
        CMD_ASN_END,
        CMD_MAP_RD,
        CMD_LOOK,
        CMD_WALK,
        CMD_WALK_NXT,
        CMD_SLIDE_INIT,
        CMD_SLIDE_RD,
        CMD_SLIDE_WR,
        CMD_ZERO_INIT,
        CMD_ZERO_WR,
        CMD_FREE_END,
        CMD_RAM_ACC,
        CMD_RAM_DONE,
        CMD_FAIL
    } t_cmd;

    typedef struct packed {
        logic  clr_last;
        logic  pid_ok;
        t_kind kind;
        logic  size_zero;
        logic  vp_ok;
        logic  map_hit;
        logic  cnt_reach;
        logic  idx_last;
        logic  brk_ok;
        logic  j_reach;
        logic  walk_more;
        logic  k_lt_b;
        logic  pa_ok;
    } t_status;

endpackage

/* sv/paged_frame_allocator_mmu.sv */
// Top level of the paged frame allocator and per-process address translator.
// Instantiates pfa_ctrl and pfa_dp; depends on pfa_pkg.
//
// After reset the block sweeps its frame, page map and byte memories clear, one
// entry per cycle, with busy high. A request is taken when start is high and
// busy is low; its result word appears for exactly one cycle with o_done high,
// and the receiver cannot stall it. Allocate scans the frame table twice: once
// to count free frames and once to claim and map them. Free walks the released
// chain on the frame and link tables, then slides the later pages down and
// drops the freed mappings on the page map port.
// One request is in progress at a time.
module paged_frame_allocator_mmu
    import pfa_pkg::*;
#(
    parameter int OFFSET_BITS   = OFFSET_BITS_DEF,
    parameter int FRAME_COUNT   = FRAME_COUNT_DEF,
    parameter int MEMORY_BYTES  = MEMORY_BYTES_DEF,
    parameter int PROCESS_COUNT = PROCESS_COUNT_DEF
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [PID_W-1:0]  i_pid,
    input  logic [ADDR_W-1:0] i_address,
    input  logic [SIZE_W-1:0] i_size,
    input  logic [DATA_W-1:0] i_write_data,
    output logic              o_done,
    output logic              o_status,
    output logic [ADDR_W-1:0] o_alloc_address,
    output logic [DATA_W-1:0] o_read_data
);

    t_cmd    cmd;
    t_status st;

    pfa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_st    (st),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    pfa_dp #(
        .OFFSET_BITS   (OFFSET_BITS),
        .FRAME_COUNT   (FRAME_COUNT),
        .MEMORY_BYTES  (MEMORY_BYTES),
        .PROCESS_COUNT (PROCESS_COUNT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_st            (st),
        .i_kind          (i_kind),
        .i_pid           (i_pid),
        .i_address       (i_address),
        .i_size          (i_size),
        .i_write_data    (i_write_data),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_alloc_address (o_alloc_address),
        .o_read_data     (o_read_data)
    );

endmodule

/* sv/pfa_ctrl.sv */
// Sequencer of the paged frame allocator.
// Steps each request through its phases and issues one datapath command per cycle.
// Depends on pfa_pkg.
module pfa_ctrl
    import pfa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_st,
    output t_cmd    o_cmd,
    output logic    o_busy
);

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_CNT_RD,
        S_CNT_CHK,
        S_BRK,
        S_ASN_RD,
        S_ASN_CHK,
        S_ASN_END,
        S_LOOKUP,
        S_RAM,
        S_RAM_DONE,
        S_WALK,
        S_WALK_NXT,
        S_SLIDE_INIT,
        S_SLIDE_RD,
        S_SLIDE_WR,
        S_ZERO,
        S_FAIL
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        case (r_state)
            S_CLEAR: begin
                o_cmd = CMD_CLEAR;
                if (i_st.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd   = CMD_LATCH;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (!i_st.pid_ok) begin
                    n_state = S_FAIL;
                end else if (i_st.kind == KIND_ALLOC) begin
                    n_state = i_st.size_zero ? S_FAIL : S_CNT_RD;
                end else if (!i_st.vp_ok) begin
                    n_state = S_FAIL;
                end else begin
                    o_cmd   = CMD_MAP_RD;
                    n_state = S_LOOKUP;
                end
            end
            S_CNT_RD: begin
                o_cmd   = CMD_OWN_RD;
                n_state = S_CNT_CHK;
            end
            S_CNT_CHK: begin
                o_cmd = CMD_CNT_CHK;
                if (i_st.cnt_reach) begin
                    n_state = S_BRK;
                end else if (i_st.idx_last) begin
                    n_state = S_FAIL;
                end else begin
                    n_state = S_CNT_RD;
                end
            end
            S_BRK: begin
                if (i_st.brk_ok) begin
                    o_cmd   = CMD_ASN_INIT;
                    n_state = S_ASN_RD;
                end else begin
                    n_state = S_FAIL;
                end
            end
            S_ASN_RD: begin
                o_cmd   = CMD_OWN_RD;
                n_state = S_ASN_CHK;
            end
            S_ASN_CHK: begin
                o_cmd   = CMD_ASN_CHK;
                n_state = i_st.j_reach ? S_ASN_END : S_ASN_RD;
            end
            S_ASN_END: begin
                o_cmd   = CMD_ASN_END;
                n_state = S_IDLE;
            end
            S_LOOKUP: begin
                if (!i_st.map_hit) begin
                    n_state = S_FAIL;
                end else begin
                    o_cmd   = CMD_LOOK;
                    n_state = (i_st.kind == KIND_FREE) ? S_WALK : S_RAM;
                end
            end
            S_RAM: begin
                if (i_st.pa_ok) begin
                    o_cmd   = CMD_RAM_ACC;
                    n_state = S_RAM_DONE;
                end else begin
                    n_state = S_FAIL;
                end
            end
            S_RAM_DONE: begin
                o_cmd   = CMD_RAM_DONE;
                n_state = S_IDLE;
            end
            S_WALK: begin
                o_cmd   = CMD_WALK;
                n_state = S_WALK_NXT;
            end
            S_WALK_NXT: begin
                o_cmd   = CMD_WALK_NXT;
                n_state = i_st.walk_more ? S_WALK : S_SLIDE_INIT;
            end
            S_SLIDE_INIT: begin
                o_cmd   = CMD_SLIDE_INIT;
                n_state = S_SLIDE_RD;
            end
            S_SLIDE_RD: begin
                if (i_st.k_lt_b) begin
                    o_cmd   = CMD_SLIDE_RD;
                    n_state = S_SLIDE_WR;
                end else begin
                    o_cmd   = CMD_ZERO_INIT;
                    n_state = S_ZERO;
                end
            end
            S_SLIDE_WR: begin
                o_cmd   = CMD_SLIDE_WR;
                n_state = S_SLIDE_RD;
            end
            S_ZERO: begin
                if (i_st.k_lt_b) begin
                    o_cmd = CMD_ZERO_WR;
                end else begin
                    o_cmd   = CMD_FREE_END;
                    n_state = S_IDLE;
                end
            end
            S_FAIL: begin
                o_cmd   = CMD_FAIL;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    // A taken request must hold off the next one until its word is out.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("request taken but sequencer did not go busy");

endmodule

/* sv/pfa_dp.sv */
// Datapath of the paged frame allocator: frame, link, page map and byte memories,
// the per-process break pointers, scan counters and the result word registers.
// Depends on pfa_pkg; driven by commands from pfa_ctrl.
module pfa_dp
    import pfa_pkg::*;
#(
    parameter int OFFSET_BITS   = OFFSET_BITS_DEF,
    parameter int FRAME_COUNT   = FRAME_COUNT_DEF,
    parameter int MEMORY_BYTES  = MEMORY_BYTES_DEF,
    parameter int PROCESS_COUNT = PROCESS_COUNT_DEF
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_status           o_st,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [PID_W-1:0]  i_pid,
    input  logic [ADDR_W-1:0] i_address,
    input  logic [SIZE_W-1:0] i_size,
    input  logic [DATA_W-1:0] i_write_data,
    output logic              o_done,
    output logic              o_status,
    output logic [ADDR_W-1:0] o_alloc_address,
    output logic [DATA_W-1:0] o_read_data
);

    localparam int PAGE_BYTES = 1 << OFFSET_BITS;
    localparam int VPAGES     = MEMORY_BYTES >> OFFSET_BITS;
    localparam int VPW        = (VPAGES > 1) ? $clog2(VPAGES) : 1;
    localparam int FW         = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int PW         = (PROCESS_COUNT > 1) ? $clog2(PROCESS_COUNT) : 1;
    localparam int AW         = $clog2(MEMORY_BYTES);
    localparam int MIW        = PW + VPW;
    localparam int MAP_DEPTH  = PROCESS_COUNT * (1 << VPW);
    localparam int BPMAX      = (MEMORY_BYTES > PAGE_BYTES) ? MEMORY_BYTES : PAGE_BYTES;
    localparam int BPW        = $clog2(BPMAX + 1);
    localparam int NW         = SIZE_W + 1 - OFFSET_BITS;
    localparam int CW         = ((NW > FW + 1) ? NW : FW + 1) + 1;
    localparam int SW         = ((BPW > SIZE_W + 1) ? BPW : SIZE_W + 1) + 1;
    localparam int KW         = ((VPW > FW + 1) ? VPW : FW + 1) + 2;
    localparam int BW         = VPW + 1;
    localparam int DW         = FW + 1 + OFFSET_BITS;
    localparam int DCW        = ((DW > BPW) ? DW : BPW) + 1;
    localparam int PAW        = FW + OFFSET_BITS;
    localparam int PCW        = ((PAW > AW + 1) ? PAW : AW + 1) + 1;
    localparam int CLR_A      = (MEMORY_BYTES > MAP_DEPTH) ? MEMORY_BYTES : MAP_DEPTH;
    localparam int CLR_LEN    = (CLR_A > FRAME_COUNT) ? CLR_A : FRAME_COUNT;
    localparam int CLRW       = $clog2(CLR_LEN);
    localparam int LW         = FW + 1;
    localparam int MW         = FW + 1;

    // Memories.
    logic              r_own_mem  [FRAME_COUNT];
    logic [LW-1:0]     r_link_mem [FRAME_COUNT];
    logic [MW-1:0]     r_map_mem  [MAP_DEPTH];
    logic [DATA_W-1:0] r_ram_mem  [MEMORY_BYTES];
    logic              r_own_q;
    logic [LW-1:0]     r_link_q;
    logic [MW-1:0]     r_map_q;
    logic [DATA_W-1:0] r_ram_q;

    // Request and walk registers.
    t_kind             r_kind;
    logic [PID_W-1:0]  r_pid;
    logic [ADDR_W-1:0] r_addr;
    logic [NW-1:0]     r_n;
    logic [DATA_W-1:0] r_wdata;
    logic [FW-1:0]     r_idx;
    logic [FW:0]       r_cnt;
    logic [FW:0]       r_j;
    logic [FW-1:0]     r_prev;
    logic              r_have_prev;
    logic [FW-1:0]     r_f;
    logic [FW:0]       r_freed;
    logic [KW-1:0]     r_k;
    logic [BW-1:0]     r_b;
    logic [BPW-1:0]    r_bp [PROCESS_COUNT];
    logic [CLRW-1:0]   r_clr;

    logic              r_done;
    logic              r_status;
    logic [ADDR_W-1:0] r_alloc_address;
    logic [DATA_W-1:0] r_read_data;

    // Derived values.
    logic [PW-1:0]     p;
    logic [BPW-1:0]    bp_cur;
    logic [ADDR_W-1:0] vp_full;
    logic [SIZE_W:0]   n_sum;
    logic              own_free;
    logic [BPW-1:0]    bpg;
    logic [BW-1:0]     b_calc;
    logic [VPW-1:0]    asn_vidx;
    logic [KW-1:0]     lo;
    logic [DCW-1:0]    drop;
    logic [BPW-1:0]    bp_free;
    logic [BPW-1:0]    bp_alloc;
    logic [PAW-1:0]    pa;
    logic              link_more;

    logic              own_we;
    logic [FW-1:0]     own_wa;
    logic              own_wd;
    logic              link_we;
    logic [FW-1:0]     link_wa;
    logic [LW-1:0]     link_wd;
    logic              map_we;
    logic [MIW-1:0]    map_wa;
    logic [MW-1:0]     map_wd;
    logic [MIW-1:0]    map_ra;
    logic              ram_we;
    logic [AW-1:0]     ram_wa;
    logic [DATA_W-1:0] ram_wd;

    assign p        = PW'(r_pid - PID_W'(1));
    assign bp_cur   = r_bp[p];
    assign vp_full  = r_addr >> OFFSET_BITS;
    assign n_sum    = (SIZE_W + 1)'(i_size) + (SIZE_W + 1)'(PAGE_BYTES - 1);
    assign own_free = !r_own_q;
    assign bpg      = bp_cur >> OFFSET_BITS;
    assign b_calc   = (bpg > BPW'(VPAGES)) ? BW'(VPAGES) : BW'(bpg);
    // Only the low bits matter: the mapped page always lies below the page count.
    assign asn_vidx = VPW'(bpg) + VPW'(r_j);
    assign lo       = (KW'(r_b) > KW'(r_freed)) ? KW'(r_b) - KW'(r_freed) : '0;
    assign drop     = DCW'(r_freed) << OFFSET_BITS;
    assign bp_free  = (drop >= DCW'(bp_cur)) ? '0 : BPW'(DCW'(bp_cur) - drop);
    assign bp_alloc = BPW'(SW'(bp_cur) + (SW'(r_n) << OFFSET_BITS));
    assign pa       = {r_f, r_addr[OFFSET_BITS-1:0]};
    assign link_more = !r_link_q[LW-1]
                    && ((FW + 1)'(r_link_q[FW-1:0]) < (FW + 1)'(FRAME_COUNT));

    always_comb begin
        o_st           = '0;
        o_st.clr_last  = (r_clr == CLRW'(CLR_LEN - 1));
        o_st.pid_ok    = (r_pid != '0) && (7'(r_pid) <= 7'(PROCESS_COUNT));
        o_st.kind      = r_kind;
        o_st.size_zero = (r_n == '0);
        o_st.vp_ok     = ({1'b0, vp_full} < (ADDR_W + 1)'(VPAGES));
        o_st.map_hit   = r_map_q[MW-1]
                      && ((FW + 1)'(r_map_q[FW-1:0]) < (FW + 1)'(FRAME_COUNT));
        o_st.cnt_reach = (CW'(r_cnt) + CW'(own_free)) >= CW'(r_n);
        o_st.idx_last  = (r_idx == FW'(FRAME_COUNT - 1));
        o_st.brk_ok    = (SW'(bp_cur) + (SW'(r_n) << OFFSET_BITS)) <= SW'(MEMORY_BYTES);
        o_st.j_reach   = own_free && ((CW'(r_j) + CW'(1)) == CW'(r_n));
        o_st.walk_more = link_more && (r_freed != (FW + 1)'(FRAME_COUNT));
        o_st.k_lt_b    = (r_k < KW'(r_b));
        o_st.pa_ok     = (PCW'(pa) < PCW'(MEMORY_BYTES));
    end

    // Write and read port selection for the memories.
    always_comb begin
        own_we  = 1'b0;
        own_wa  = r_idx;
        own_wd  = 1'b0;
        link_we = 1'b0;
        link_wa = r_prev;
        link_wd = {1'b0, r_idx};
        map_we  = 1'b0;
        map_wa  = {p, asn_vidx};
        map_wd  = '0;
        map_ra  = {p, vp_full[VPW-1:0]};
        ram_we  = 1'b0;
        ram_wa  = AW'(pa);
        ram_wd  = r_wdata;
        case (i_cmd)
            CMD_CLEAR: begin
                own_we = ({1'b0, r_clr} < (CLRW + 1)'(FRAME_COUNT));
                own_wa = r_clr[FW-1:0];
                map_we = ({1'b0, r_clr} < (CLRW + 1)'(MAP_DEPTH));
                map_wa = r_clr[MIW-1:0];
                ram_we = ({1'b0, r_clr} < (CLRW + 1)'(MEMORY_BYTES));
                ram_wa = r_clr[AW-1:0];
                ram_wd = '0;
            end
            CMD_ASN_CHK: begin
                own_we  = own_free;
                own_wd  = 1'b1;
                link_we = own_free && r_have_prev;
                map_we  = own_free;
                map_wd  = {1'b1, r_idx};
            end
            CMD_ASN_END: begin
                link_we = 1'b1;
                link_wd = {1'b1, FW'(0)};
            end
            CMD_WALK: begin
                own_we = 1'b1;
                own_wa = r_f;
            end
            CMD_SLIDE_RD: begin
                map_ra = {p, VPW'(r_k)};
            end
            CMD_SLIDE_WR: begin
                map_we = 1'b1;
                map_wa = {p, VPW'(r_k - KW'(r_freed))};
                map_wd = r_map_q;
            end
            CMD_ZERO_WR: begin
                map_we = 1'b1;
                map_wa = {p, VPW'(r_k)};
            end
            CMD_RAM_ACC: begin
                ram_we = (r_kind == KIND_WRITE);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (own_we) begin
            r_own_mem[own_wa] <= own_wd;
        end
        if (link_we) begin
            r_link_mem[link_wa] <= link_wd;
        end
        if (map_we) begin
            r_map_mem[map_wa] <= map_wd;
        end
        if (ram_we) begin
            r_ram_mem[ram_wa] <= ram_wd;
        end
        if (i_cmd == CMD_OWN_RD) begin
            r_own_q <= r_own_mem[r_idx];
        end
        if (i_cmd == CMD_WALK) begin
            r_link_q <= r_link_mem[r_f];
        end
        if ((i_cmd == CMD_MAP_RD) || (i_cmd == CMD_SLIDE_RD)) begin
            r_map_q <= r_map_mem[map_ra];
        end
        if ((i_cmd == CMD_RAM_ACC) && (r_kind == KIND_READ)) begin
            r_ram_q <= r_ram_mem[AW'(pa)];
        end
    end

    // Request registers and scan counters.
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_LATCH: begin
                r_kind  <= t_kind'(i_kind);
                r_pid   <= i_pid;
                r_addr  <= i_address;
                r_n     <= NW'(n_sum >> OFFSET_BITS);
                r_wdata <= i_write_data;
                r_idx   <= '0;
                r_cnt   <= '0;
            end
            CMD_CNT_CHK: begin
                r_cnt <= r_cnt + (FW + 1)'(own_free);
                r_idx <= r_idx + FW'(1);
            end
            CMD_ASN_INIT: begin
                r_idx       <= '0;
                r_j         <= '0;
                r_have_prev <= 1'b0;
            end
            CMD_ASN_CHK: begin
                r_idx <= r_idx + FW'(1);
                if (own_free) begin
                    r_j         <= r_j + (FW + 1)'(1);
                    r_prev      <= r_idx;
                    r_have_prev <= 1'b1;
                end
            end
            CMD_LOOK: begin
                r_f     <= r_map_q[FW-1:0];
                r_freed <= '0;
            end
            CMD_WALK: begin
                r_freed <= r_freed + (FW + 1)'(1);
            end
            CMD_WALK_NXT: begin
                if (link_more) begin
                    r_f <= r_link_q[FW-1:0];
                end
            end
            CMD_SLIDE_INIT: begin
                r_k <= KW'(vp_full) + KW'(r_freed);
                r_b <= b_calc;
            end
            CMD_SLIDE_WR, CMD_ZERO_WR: begin
                r_k <= r_k + KW'(1);
            end
            CMD_ZERO_INIT: begin
                r_k <= lo;
            end
            default: begin
            end
        endcase
    end

    // Break pointers, clearing sweep and the result word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_done <= 1'b0;
            for (int i = 0; i < PROCESS_COUNT; i++) begin
                r_bp[i] <= BPW'(PAGE_BYTES);
            end
        end else begin
            r_done <= 1'b0;
            case (i_cmd)
                CMD_CLEAR: begin
                    r_clr <= r_clr + CLRW'(1);
                end
                CMD_ASN_END: begin
                    r_bp[p]         <= bp_alloc;
                    r_done          <= 1'b1;
                    r_status        <= 1'b0;
                    r_alloc_address <= ADDR_W'(bp_cur);
                    r_read_data     <= '0;
                end
                CMD_FREE_END: begin
                    r_bp[p]         <= bp_free;
                    r_done          <= 1'b1;
                    r_status        <= 1'b0;
                    r_alloc_address <= '0;
                    r_read_data     <= '0;
                end
                CMD_RAM_DONE: begin
                    r_done          <= 1'b1;
                    r_status        <= 1'b0;
                    r_alloc_address <= '0;
                    r_read_data     <= (r_kind == KIND_READ) ? r_ram_q : '0;
                end
                CMD_FAIL: begin
                    r_done          <= 1'b1;
                    r_status        <= 1'b1;
                    r_alloc_address <= '0;
                    r_read_data     <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_alloc_address = r_alloc_address;
    assign o_read_data     = r_read_data;

    // Break pointers only move in whole pages, so a returned start is page aligned.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_alloc_address[OFFSET_BITS-1:0] == '0))
        else $error("allocation start is not page aligned");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_status) |-> ((r_alloc_address == '0) && (r_read_data == '0)))
        else $error("failed request returned a nonzero payload");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == CMD_CLEAR) |=> !r_done)
        else $error("result word issued during the clearing sweep");

endmodule

/* bench/paged_frame_allocator_mmu_tb.sv */
// Self-checking testbench for paged_frame_allocator_mmu: directed and random
// allocate, free, read and write requests checked against a built-in predictor.
// Depends on pfa_pkg and the paged_frame_allocator_mmu RTL.
`timescale 1ns / 100ps

module paged_frame_allocator_mmu_tb;
    import pfa_pkg::*;

    localparam int          PAGE_SH = OFFSET_BITS_DEF;
    localparam int unsigned PAGE    = 1 << PAGE_SH;
    localparam int unsigned FRAMES  = FRAME_COUNT_DEF;
    localparam int unsigned MEM     = MEMORY_BYTES_DEF;
    localparam int unsigned PROCS   = PROCESS_COUNT_DEF;
    localparam int unsigned VPAGES  = MEM >> PAGE_SH;
    localparam logic [31:0] MAP_VALID = 32'h8000_0000;
    localparam logic [31:0] LINK_END  = 32'h8000_0000;

    typedef struct {
        t_kind             kind;
        logic [PID_W-1:0]  pid;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
        logic [DATA_W-1:0] wdata;
        logic              status;
        logic [ADDR_W-1:0] start_addr;
        logic [DATA_W-1:0] rdata;
    } t_mem_req;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [KIND_W-1:0] i_kind;
    logic [PID_W-1:0]  i_pid;
    logic [ADDR_W-1:0] i_address;
    logic [SIZE_W-1:0] i_size;
    logic [DATA_W-1:0] i_write_data;
    logic              o_done;
    logic              o_status;
    logic [ADDR_W-1:0] o_alloc_address;
    logic [DATA_W-1:0] o_read_data;

    // Predictor copy of the block state.
    logic [3:0]  owner_tbl [FRAMES];
    logic [31:0] link_tbl  [FRAMES];
    logic [31:0] map_tbl   [PROCS*VPAGES];
    int unsigned brk_tbl   [PROCS];
    logic [7:0]  ram_img   [MEM];

    t_mem_req pending_q[$];
    t_mem_req outcome_q[$];
    t_mem_req in_flight;
    int       gap_pct;
    bit       failed;

    paged_frame_allocator_mmu dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_kind          (i_kind),
        .i_pid           (i_pid),
        .i_address       (i_address),
        .i_size          (i_size),
        .i_write_data    (i_write_data),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_alloc_address (o_alloc_address),
        .o_read_data     (o_read_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic bit translate(int unsigned p, int unsigned addr,
                                     output int unsigned frame);
        int unsigned vp;
        logic [31:0] e;
        vp = addr >> PAGE_SH;
        frame = 0;
        if (vp >= VPAGES) return 0;
        e = map_tbl[p*VPAGES + vp];
        if ((e & MAP_VALID) == 0) return 0;
        frame = e & ~MAP_VALID;
        return frame < FRAMES;
    endfunction

    function automatic bit model_alloc(int unsigned p, int unsigned pid, int unsigned size,
                                       output int unsigned base_addr);
        int unsigned n, cnt, j, prev, vp, bp;
        n = (size + PAGE - 1) >> PAGE_SH;
        cnt = 0;
        j = 0;
        prev = 0;
        base_addr = 0;
        if (n == 0) return 0;
        for (int unsigned f = 0; f < FRAMES && cnt < n; f++)
            if (owner_tbl[f] == 0) cnt++;
        if (cnt < n) return 0;
        bp = brk_tbl[p];
        if (longint'(bp) + longint'(n) * PAGE > longint'(MEM)) return 0;
        vp = bp >> PAGE_SH;
        for (int unsigned f = 0; f < FRAMES && j < n; f++) begin
            if (owner_tbl[f] != 0) continue;
            owner_tbl[f] = pid[3:0];
            if (j != 0) link_tbl[prev] = f;
            map_tbl[p*VPAGES + vp + j] = MAP_VALID | f;
            prev = f;
            j++;
        end
        link_tbl[prev] = LINK_END;
        brk_tbl[p] = bp + n * PAGE;
        base_addr = bp & 32'hFFFFF;
        return 1;
    endfunction

    function automatic bit model_free(int unsigned p, int unsigned addr);
        int unsigned f, freed, s, b, lo, base;
        logic [31:0] l;
        longint drop;
        freed = 0;
        if (!translate(p, addr, f)) return 0;
        for (int unsigned steps = 0; steps < FRAMES; steps++) begin
            owner_tbl[f] = 0;
            freed++;
            l = link_tbl[f];
            if ((l & LINK_END) != 0 || l >= FRAMES) break;
            f = l;
        end
        s = addr >> PAGE_SH;
        b = brk_tbl[p] >> PAGE_SH;
        if (b > VPAGES) b = VPAGES;
        base = p * VPAGES;
        for (int unsigned k = s + freed; k < b; k++)
            map_tbl[base + k - freed] = map_tbl[base + k];
        lo = (b > freed) ? b - freed : 0;
        for (int unsigned k = lo; k < b; k++)
            map_tbl[base + k] = 0;
        drop = longint'(freed) * PAGE;
        if (drop >= longint'(brk_tbl[p])) brk_tbl[p] = 0;
        else brk_tbl[p] -= int'(drop);
        return 1;
    endfunction

    // Applies one request to the predictor state and fills in its expected result word.
    task automatic predict_and_queue(t_kind kind, int unsigned pid, int unsigned addr,
                                     int unsigned size, int unsigned wdata);
        t_mem_req r;
        int unsigned p, f, base_addr;
        longint pa;
        r.kind = kind;
        r.pid = pid[PID_W-1:0];
        r.addr = addr[ADDR_W-1:0];
        r.size = size[SIZE_W-1:0];
        r.wdata = wdata[DATA_W-1:0];
        r.status = 1'b1;
        r.start_addr = '0;
        r.rdata = '0;
        if (r.pid != 0 && r.pid <= PROCS) begin
            p = r.pid - 1;
            if (kind == KIND_ALLOC) begin
                if (model_alloc(p, r.pid, r.size, base_addr)) begin
                    r.status = 1'b0;
                    r.start_addr = base_addr[ADDR_W-1:0];
                end
            end else if (kind == KIND_FREE) begin
                if (model_free(p, r.addr)) r.status = 1'b0;
            end else if (translate(p, r.addr, f)) begin
                pa = (longint'(f) << PAGE_SH) | (r.addr & (PAGE - 1));
                if (pa < longint'(MEM)) begin
                    if (kind == KIND_READ) r.rdata = ram_img[pa];
                    else ram_img[pa] = r.wdata;
                    r.status = 1'b0;
                end
            end
        end
        pending_q.push_back(r);
    endtask

    // Picks an address inside the mapped range of the process most of the time.
    function automatic int unsigned pick_addr(int unsigned pid);
        int unsigned top;
        if (pid == 0 || pid > PROCS || $urandom_range(0, 9) == 0)
            return $urandom_range(0, 20'hFFFFF);
        top = brk_tbl[pid-1] >> PAGE_SH;
        if (top <= 1) return $urandom_range(0, 4 * PAGE);
        return ($urandom_range(1, top - 1) << PAGE_SH) | $urandom_range(0, PAGE - 1);
    endfunction

    task automatic random_request();
        int unsigned pid, sel, size;
        t_kind kind;
        pid = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 15) : $urandom_range(1, PROCS);
        sel = $urandom_range(0, 99);
        if (sel < 35) kind = KIND_ALLOC;
        else if (sel < 55) kind = KIND_FREE;
        else if (sel < 77) kind = KIND_READ;
        else kind = KIND_WRITE;
        case ($urandom_range(0, 9))
            0:       size = $urandom_range(0, 21'h1FFFFF);
            1:       size = $urandom_range(0, 40000);
            default: size = $urandom_range(1, 5 * PAGE);
        endcase
        predict_and_queue(kind, pid, pick_addr(pid), size, $urandom_range(0, 255));
    endtask

    task automatic drain();
        while (pending_q.size() != 0 || start || outcome_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Request driver: a word is taken at an edge where start is high and busy is low.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || !busy) begin
            if (start) outcome_q.push_back(in_flight);
            if (pending_q.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
                in_flight = pending_q.pop_front();
                start        <= 1'b1;
                i_kind       <= in_flight.kind;
                i_pid        <= in_flight.pid;
                i_address    <= in_flight.addr;
                i_size       <= in_flight.size;
                i_write_data <= in_flight.wdata;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        t_mem_req e;
        if (i_rst_n && o_done) begin
            if (outcome_q.size() == 0) begin
                $error("result word with no request outstanding");
                failed = 1'b1;
            end else begin
                e = outcome_q.pop_front();
                if (o_status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, o_status);
                    failed = 1'b1;
                end
                if (o_alloc_address !== e.start_addr) begin
                    $error("alloc_address: expected %h, got %h", e.start_addr,
                           o_alloc_address);
                    failed = 1'b1;
                end
                if (o_read_data !== e.rdata) begin
                    $error("read_data: expected %h, got %h", e.rdata, o_read_data);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        #200ms;
        $display("paged_frame_allocator_mmu verification failed");
        $finish;
    end

    initial begin
        failed = 1'b0;
        gap_pct = 0;
        start = 1'b0;
        i_kind = KIND_ALLOC;
        i_pid = '0;
        i_address = '0;
        i_size = '0;
        i_write_data = '0;
        for (int i = 0; i < FRAMES; i++) begin
            owner_tbl[i] = '0;
            link_tbl[i] = '0;
        end
        for (int i = 0; i < PROCS*VPAGES; i++) map_tbl[i] = '0;
        for (int i = 0; i < PROCS; i++) brk_tbl[i] = PAGE;
        for (int i = 0; i < MEM; i++) ram_img[i] = '0;

        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: bad pids, zero and oversize sizes, unmapped accesses,
        // frees inside a region, and running the frame pool dry.
        predict_and_queue(KIND_ALLOC, 0, 0, PAGE, 0);
        predict_and_queue(KIND_ALLOC, 9, 0, PAGE, 0);
        predict_and_queue(KIND_READ, 15, PAGE, 0, 0);
        predict_and_queue(KIND_ALLOC, 1, 0, 0, 0);
        predict_and_queue(KIND_ALLOC, 1, 0, MEM, 0);
        predict_and_queue(KIND_ALLOC, 2, 0, 21'h1FFFFF, 0);
        predict_and_queue(KIND_READ, 1, PAGE, 0, 0);
        predict_and_queue(KIND_ALLOC, 1, 0, 3 * PAGE + 1, 0);
        predict_and_queue(KIND_WRITE, 1, PAGE + 5, 0, 8'hFF);
        predict_and_queue(KIND_WRITE, 1, 4 * PAGE + 1023, 0, 8'h00);
        predict_and_queue(KIND_READ, 1, PAGE + 5, 0, 0);
        predict_and_queue(KIND_ALLOC, 8, 0, 2 * PAGE, 0);
        predict_and_queue(KIND_WRITE, 8, 2 * PAGE + 3, 0, 8'hA5);
        predict_and_queue(KIND_FREE, 1, 2 * PAGE + 7, 0, 0);
        predict_and_queue(KIND_READ, 1, PAGE + 5, 0, 0);
        predict_and_queue(KIND_READ, 1, 2 * PAGE, 0, 0);
        predict_and_queue(KIND_FREE, 1, 20'hFFFFF, 0, 0);
        predict_and_queue(KIND_WRITE, 3, 20'hFFFFF, 0, 8'h5A);
        predict_and_queue(KIND_ALLOC, 3, 0, 1000 * PAGE, 0);
        predict_and_queue(KIND_ALLOC, 4, 0, 40 * PAGE, 0);
        predict_and_queue(KIND_FREE, 3, 500 * PAGE, 0, 0);
        predict_and_queue(KIND_READ, 8, 2 * PAGE + 3, 0, 0);
        predict_and_queue(KIND_FREE, 3, PAGE, 0, 0);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: gap_pct = 0;
                1: gap_pct = 64;
                2: gap_pct = 14;
                default: gap_pct = 0;
            endcase
            for (int i = 0; i < 67; i++) random_request();
            // The sender holds off here until every result has come back.
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (!failed && outcome_q.size() == 0) begin
            $display("paged_frame_allocator_mmu verification clean");
        end else begin
            $display("paged_frame_allocator_mmu verification failed");
        end
        $finish;
    end

endmodule
